FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cftr_pkg.sv
package cftr_pkg;

  // Defaults for the top-level parameters
  localparam int BYTE_POSITIONS_DEF = 8;
  localparam int TIME_BITS_DEF      = 32;

  // Fixed field widths
  localparam int ID_BITS       = 29;
  localparam int LEN_BITS      = 4;
  localparam int STAMP_BITS    = 32;
  localparam int PAYLOAD_BITS  = 64;
  localparam int MASK_BITS     = 8;
  localparam int BYTE_BITS     = 8;
  localparam int VALUE_COUNT   = 1 << BYTE_BITS;
  localparam int DISTINCT_BITS = BYTE_BITS + 1;

  // Running mean datapath: mean * count + gap fits in twice the mean width plus a carry
  localparam int MEAN_BITS = 32;
  localparam int SUM_BITS  = 2 * MEAN_BITS + 1;
  localparam int STEP_BITS = $clog2(MEAN_BITS);

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = ID_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_ID     = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MATCH_LENGTH = CFG_INDEX_BITS'(1);

  // Queue between front and back
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // One classified frame as it travels to the back end
  typedef struct packed {
    logic                    hit;
    logic                    extended;
    logic                    remote;
    logic [STAMP_BITS-1:0]   stamp;
    logic [PAYLOAD_BITS-1:0] payload;
  } item_t;

endpackage

FILE: sv/cftr_front.sv
module cftr_front (
  input  logic                                  clk,
  input  logic                                  rst,
  // frame channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [cftr_pkg::ID_BITS-1:0]          frame_id,
  input  logic [cftr_pkg::LEN_BITS-1:0]         frame_length,
  input  logic                                  extended_flag,
  input  logic                                  remote_flag,
  input  logic [cftr_pkg::STAMP_BITS-1:0]       arrival_time,
  input  logic [cftr_pkg::PAYLOAD_BITS-1:0]     payload,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cftr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [cftr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // back end busy with its clearing sweep
  input  logic                                  clearing,
  // towards the queue
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output cftr_pkg::item_t                       push_item
);

  logic [cftr_pkg::ID_BITS-1:0]  match_id;
  logic [cftr_pkg::LEN_BITS-1:0] match_length;

  // Register file: writes are always taken, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_id     <= '0;
      match_length <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cftr_pkg::REG_MATCH_ID:     match_id     <= cfg_data;
        cftr_pkg::REG_MATCH_LENGTH: match_length <= cfg_data[cftr_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frames are held off until the seen-maps are cleared
  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;

  // Classify the frame on the way in
  always_comb begin
    push_item.hit      = (frame_id == match_id) && (frame_length == match_length);
    push_item.extended = extended_flag;
    push_item.remote   = remote_flag;
    push_item.stamp    = arrival_time;
    push_item.payload  = payload;
  end

endmodule

FILE: sv/cftr_queue.sv
module cftr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  cftr_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cftr_pkg::item_t pop_item
);

  cftr_pkg::item_t                         slots [cftr_pkg::QUEUE_DEPTH];
  logic [cftr_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr;
  logic [cftr_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr;
  logic [cftr_pkg::QUEUE_CNT_BITS-1:0]     fill;
  logic                                    do_push;
  logic                                    do_pop;

  assign push_ready = (fill != cftr_pkg::QUEUE_CNT_BITS'(cftr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: sv/cftr_back.sv
module cftr_back #(
  parameter int BYTE_POSITIONS = cftr_pkg::BYTE_POSITIONS_DEF,
  parameter int TIME_BITS      = cftr_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // from the queue
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  cftr_pkg::item_t                   pop_item,
  // clearing sweep in progress
  output logic                              clearing,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              matched,
  output logic                              seen_extended,
  output logic                              seen_remote,
  output logic [cftr_pkg::MEAN_BITS-1:0]    mean_gap,
  output logic [cftr_pkg::MEAN_BITS-1:0]    frame_count,
  output logic [cftr_pkg::MASK_BITS-1:0]    new_value_mask
);

  localparam int MB = cftr_pkg::MEAN_BITS;
  localparam int SB = cftr_pkg::SUM_BITS;
  localparam int BB = cftr_pkg::BYTE_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  state_t                              state;
  cftr_pkg::item_t                     cur;
  logic [BB-1:0]                       clr_addr;

  // profile state
  logic                                ext_flag;
  logic                                rtr_flag;
  logic [MB-1:0]                       running_mean;
  logic [MB-1:0]                       match_total;
  logic [TIME_BITS-1:0]                previous_time;
  logic [cftr_pkg::DISTINCT_BITS-1:0]  distinct_counts [BYTE_POSITIONS];

  // mean datapath
  logic [2*MB-1:0]                     prod;
  logic [SB-1:0]                       sum_r;
  logic [MB:0]                         rem;
  logic [MB-1:0]                       quo;
  logic [cftr_pkg::STEP_BITS-1:0]      step_cnt;
  logic                                mean_upd;

  logic [2*MB-1:0]                     prod_c;
  logic [TIME_BITS-1:0]                now_t;
  logic [TIME_BITS-1:0]                gap;
  logic [MB:0]                         divisor;
  logic [MB+1:0]                       trial;
  logic [MB+1:0]                       diff;
  logic                                trial_ge;
  logic                                count_full;
  logic                                commit;

  logic [BYTE_POSITIONS-1:0]           rd_seen;
  logic [BYTE_POSITIONS-1:0]           mask_new;

  logic                                ext_next;
  logic                                rtr_next;
  logic [MB-1:0]                       mean_next;
  logic [MB-1:0]                       total_next;

  // Datapath around the mean update
  assign prod_c     = running_mean * match_total;
  assign now_t      = TIME_BITS'(cur.stamp);
  assign gap        = now_t - previous_time;
  assign divisor    = {1'b0, match_total} + {{MB{1'b0}}, 1'b1};
  assign trial      = {rem, quo[MB-1]};
  assign diff       = trial - {1'b0, divisor};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign count_full = &match_total;

  assign clearing   = (state == S_CLEAR);
  assign pop_ready  = (state == S_IDLE);
  assign commit     = (state == S_DONE) && (!out_valid || out_ready);
  assign mask_new   = cur.hit ? ~rd_seen : '0;

  // State as it stands after this frame
  assign ext_next   = ext_flag | (cur.hit & cur.extended);
  assign rtr_next   = rtr_flag | (cur.hit & cur.remote);
  assign mean_next  = mean_upd ? quo : running_mean;
  assign total_next = mean_upd ? match_total + 1'b1 : match_total;

  // Seen-maps: one 256 x 1 memory per byte position
  for (genvar i = 0; i < BYTE_POSITIONS; i++) begin : g_lane
    logic          seen_mem [cftr_pkg::VALUE_COUNT];
    logic [BB-1:0] byte_val;
    logic [BB-1:0] waddr;
    logic          we;
    logic          seen_q;

    assign byte_val = cur.payload[BB*i +: BB];
    assign waddr    = clearing ? clr_addr : byte_val;
    assign we       = clearing || (commit && mask_new[i]);

    always_ff @(posedge clk) begin
      if (we) begin
        seen_mem[waddr] <= !clearing;
      end
      seen_q <= seen_mem[byte_val];
    end

    assign rd_seen[i] = seen_q;
  end

  // Sequencer, profile state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      ext_flag      <= 1'b0;
      rtr_flag      <= 1'b0;
      running_mean  <= '0;
      match_total   <= '0;
      previous_time <= '0;
      mean_upd      <= 1'b0;
      for (int i = 0; i < BYTE_POSITIONS; i++) begin
        distinct_counts[i] <= '0;
      end
    end else begin
      // beat taken and no new one behind it
      if (out_valid && out_ready && !commit) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // one row of every seen-map per cycle
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (pop_valid) begin
            cur   <= pop_item;
            state <= S_LOAD;
          end
        end

        // seen-map reads go out this cycle; product of mean and count
        S_LOAD: begin
          prod     <= prod_c;
          mean_upd <= cur.hit && !count_full;
          if (cur.hit && !count_full) begin
            state <= S_SUM;
          end else begin
            state <= S_DONE;
          end
        end

        S_SUM: begin
          sum_r <= {1'b0, prod} + SB'(gap);
          state <= S_CHECK;
        end

        // quotient of 2^32 or more saturates, otherwise start the divider
        S_CHECK: begin
          if (sum_r[SB-1:MB] >= divisor) begin
            quo   <= '1;
            state <= S_DONE;
          end else begin
            rem      <= sum_r[SB-1:MB];
            quo      <= sum_r[MB-1:0];
            step_cnt <= cftr_pkg::STEP_BITS'(MB - 1);
            state    <= S_DIV;
          end
        end

        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (trial_ge) begin
            rem <= diff[MB:0];
            quo <= {quo[MB-2:0], 1'b1};
          end else begin
            rem <= trial[MB:0];
            quo <= {quo[MB-2:0], 1'b0};
          end
          step_cnt <= step_cnt - 1'b1;
          if (step_cnt == '0) begin
            state <= S_DONE;
          end
        end

        // update the profile and hand over the result beat
        S_DONE: begin
          if (commit) begin
            ext_flag       <= ext_next;
            rtr_flag       <= rtr_next;
            running_mean   <= mean_next;
            match_total    <= total_next;
            if (cur.hit) begin
              previous_time <= now_t;
            end
            for (int i = 0; i < BYTE_POSITIONS; i++) begin
              if (mask_new[i]) begin
                distinct_counts[i] <= distinct_counts[i] + 1'b1;
              end
            end
            out_valid      <= 1'b1;
            matched        <= cur.hit;
            seen_extended  <= ext_next;
            seen_remote    <= rtr_next;
            mean_gap       <= mean_next;
            frame_count    <= total_next;
            new_value_mask <= cftr_pkg::MASK_BITS'(mask_new);
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/can_frame_profile_tracker.sv
// CAN frame profiler for one identifier and payload length. A matching frame goes
// through load, sum, check and the one-bit-per-cycle divider that folds the
// arrival gap into the running mean; a frame that does not match, or one that
// matches once the count has saturated, goes from load to done, and with TIME_BITS
// above 32 a gap pushing the mean past 32 bits saturates it in the check state.
// Two frames can wait in the queue behind the one being worked on. A finished result
// beat waits in the output register; the next frame is worked on but held at done
// until that beat is taken. After reset each position's seen-map is swept clear one
// row per cycle; in_ready stays low until then, while register writes are taken.
`include "assert_macros.svh"

module can_frame_profile_tracker #(
  parameter int BYTE_POSITIONS = cftr_pkg::BYTE_POSITIONS_DEF,
  parameter int TIME_BITS      = cftr_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // frame channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cftr_pkg::ID_BITS-1:0]        frame_id,
  input  logic [cftr_pkg::LEN_BITS-1:0]       frame_length,
  input  logic                                extended_flag,
  input  logic                                remote_flag,
  input  logic [cftr_pkg::STAMP_BITS-1:0]     arrival_time,
  input  logic [cftr_pkg::PAYLOAD_BITS-1:0]   payload,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                matched,
  output logic                                seen_extended,
  output logic                                seen_remote,
  output logic [cftr_pkg::MEAN_BITS-1:0]      mean_gap,
  output logic [cftr_pkg::MEAN_BITS-1:0]      frame_count,
  output logic [cftr_pkg::MASK_BITS-1:0]      new_value_mask,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cftr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cftr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic            clearing;
  logic            push_valid;
  logic            push_ready;
  cftr_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  cftr_pkg::item_t pop_item;
  logic            any_flag;

  // Front: register file and frame classification
  cftr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .frame_id      (frame_id),
    .frame_length  (frame_length),
    .extended_flag (extended_flag),
    .remote_flag   (remote_flag),
    .arrival_time  (arrival_time),
    .payload       (payload),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .clearing      (clearing),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  // Queue of classified frames
  cftr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: profile update and result register
  cftr_back #(
    .BYTE_POSITIONS (BYTE_POSITIONS),
    .TIME_BITS      (TIME_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .matched        (matched),
    .seen_extended  (seen_extended),
    .seen_remote    (seen_remote),
    .mean_gap       (mean_gap),
    .frame_count    (frame_count),
    .new_value_mask (new_value_mask)
  );

  // Checks
  assign any_flag = seen_extended || seen_remote;

  `ASSERT_IMPLIES(a_nomatch_mask, clk, rst, out_valid && !matched, ~|new_value_mask, "mask on miss")
  `ASSERT_IMPLIES(a_flags_count, clk, rst, out_valid && any_flag, frame_count != '0, "count zero")
  `ASSERT_IMPLIES(a_match_count, clk, rst, out_valid && matched, frame_count != '0, "zero count")
  `ASSERT_IMPLIES(a_clear_quiet, clk, rst, clearing, !out_valid && !pop_ready, "beat during clear")

endmodule

FILE: tb/tb_can_frame_profile_tracker.sv
`timescale 1ns / 1ps

module tb_can_frame_profile_tracker;

  // Widths taken from the package
  localparam int ID_BITS            = cftr_pkg::ID_BITS;
  localparam int LEN_BITS           = cftr_pkg::LEN_BITS;
  localparam int STAMP_BITS         = cftr_pkg::STAMP_BITS;
  localparam int PAYLOAD_BITS       = cftr_pkg::PAYLOAD_BITS;
  localparam int MEAN_BITS          = cftr_pkg::MEAN_BITS;
  localparam int MASK_BITS          = cftr_pkg::MASK_BITS;
  localparam int BYTE_BITS          = cftr_pkg::BYTE_BITS;
  localparam int VALUE_COUNT        = cftr_pkg::VALUE_COUNT;
  localparam int SUM_BITS           = cftr_pkg::SUM_BITS;
  localparam int CFG_INDEX_BITS     = cftr_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS      = cftr_pkg::CFG_DATA_BITS;
  localparam int BYTE_POSITIONS_DEF = cftr_pkg::BYTE_POSITIONS_DEF;

  // Out-of-range register indexes, writes to them must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = CFG_INDEX_BITS'(3);
  localparam int PROFILE_PHASES = 8;
  localparam int FRAMES_PER_PHASE = 240;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum int {
    KIND_MATCH, KIND_ID_FLIP, KIND_LEN_OTHER, KIND_ANY, KIND_ANY_LEN
  } frame_kind_t;

  typedef struct packed {
    logic [ID_BITS-1:0]      id;
    logic [LEN_BITS-1:0]     len;
    logic                    ext;
    logic                    rtr;
    logic [STAMP_BITS-1:0]   stamp;
    logic [PAYLOAD_BITS-1:0] payload;
  } can_frame_t;

  typedef struct packed {
    logic                 matched;
    logic                 seen_ext;
    logic                 seen_rtr;
    logic [MEAN_BITS-1:0] mean;
    logic [MEAN_BITS-1:0] count;
    logic [MASK_BITS-1:0] mask;
  } profile_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [ID_BITS-1:0]        frame_id;
  logic [LEN_BITS-1:0]       frame_length;
  logic                      extended_flag;
  logic                      remote_flag;
  logic [STAMP_BITS-1:0]     arrival_time;
  logic [PAYLOAD_BITS-1:0]   payload;
  logic                      out_valid;
  logic                      out_ready;
  logic                      matched;
  logic                      seen_extended;
  logic                      seen_remote;
  logic [MEAN_BITS-1:0]      mean_gap;
  logic [MEAN_BITS-1:0]      frame_count;
  logic [MASK_BITS-1:0]      new_value_mask;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  can_frame_profile_tracker dut (.*);

  // Shadow copy of the profiler state
  logic [VALUE_COUNT-1:0] seen_values [BYTE_POSITIONS_DEF];
  logic [MEAN_BITS-1:0]   mean_acc;
  logic [MEAN_BITS-1:0]   count_acc;
  logic [STAMP_BITS-1:0]  last_stamp;
  logic                   sticky_ext;
  logic                   sticky_rtr;
  logic [ID_BITS-1:0]     watch_id;
  logic [LEN_BITS-1:0]    watch_len;

  profile_result_t expected_profiles[$];

  int unsigned frames_sent;
  int unsigned hits_sent;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;

  // Receiver behaviour, written only by the stimulus side
  rx_mode_t rx_mode;
  int unsigned hold_len;
  int unsigned hold_token;

  // Receiver-private
  int unsigned rx_cycle;
  int unsigned hold_left;
  int unsigned hold_seen;

  // Stimulus-side timestamp and payload history
  logic [STAMP_BITS-1:0]   stamp_now;
  logic [PAYLOAD_BITS-1:0] last_payload;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work out the result of one accepted frame and advance the shadow state
  function automatic profile_result_t profile_frame(input can_frame_t f);
    profile_result_t r;
    logic [STAMP_BITS-1:0] gap;
    logic [SUM_BITS-1:0]   weighted;
    logic [BYTE_BITS-1:0]  b;
    r = '0;
    r.matched = (f.id == watch_id) && (f.len == watch_len);
    if (r.matched) begin
      gap = f.stamp - last_stamp;
      sticky_ext = sticky_ext | f.ext;
      sticky_rtr = sticky_rtr | f.rtr;
      // count and mean freeze once the count is all ones
      if (count_acc != '1) begin
        weighted = SUM_BITS'(mean_acc) * SUM_BITS'(count_acc) + SUM_BITS'(gap);
        weighted = weighted / (SUM_BITS'(count_acc) + SUM_BITS'(1));
        mean_acc = weighted[MEAN_BITS-1:0];
        count_acc = count_acc + 1'b1;
      end
      last_stamp = f.stamp;
      for (int i = 0; i < BYTE_POSITIONS_DEF; i++) begin
        b = f.payload[i*BYTE_BITS +: BYTE_BITS];
        if (!seen_values[i][b]) begin
          seen_values[i][b] = 1'b1;
          r.mask[i] = 1'b1;
        end
      end
    end
    r.seen_ext = sticky_ext;
    r.seen_rtr = sticky_rtr;
    r.mean = mean_acc;
    r.count = count_acc;
    return r;
  endfunction

  function automatic can_frame_t make_frame(input logic [ID_BITS-1:0] id,
                                            input logic [LEN_BITS-1:0] len,
                                            input logic ext, input logic rtr,
                                            input logic [STAMP_BITS-1:0] stamp,
                                            input logic [PAYLOAD_BITS-1:0] data);
    can_frame_t f;
    f.id = id;
    f.len = len;
    f.ext = ext;
    f.rtr = rtr;
    f.stamp = stamp;
    f.payload = data;
    return f;
  endfunction

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
      mismatch_count++;
    end
  endtask

  // Compare one result beat against the oldest outstanding prediction
  task automatic check_result();
    profile_result_t want;
    if (expected_profiles.size() == 0) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("[%0t] result beat with nothing outstanding", $realtime);
      mismatch_count++;
      return;
    end
    want = expected_profiles.pop_front();
    results_checked++;
    compare_field("matched", 64'(want.matched), 64'(matched));
    compare_field("seen_extended", 64'(want.seen_ext), 64'(seen_extended));
    compare_field("seen_remote", 64'(want.seen_rtr), 64'(seen_remote));
    compare_field("mean_gap", 64'(want.mean), 64'(mean_gap));
    compare_field("frame_count", 64'(want.count), 64'(frame_count));
    compare_field("new_value_mask", 64'(want.mask), 64'(new_value_mask));
  endtask

  // Result side: check accepted beats, then pick out_ready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_valid && out_ready)
        check_result();
      rx_cycle++;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(0, 9) > 2);
          RX_PATTERN: out_ready <= ((rx_cycle % 7) < 4);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_frame(input can_frame_t f);
    in_valid <= 1'b1;
    frame_id <= f.id;
    frame_length <= f.len;
    extended_flag <= f.ext;
    remote_flag <= f.rtr;
    arrival_time <= f.stamp;
    payload <= f.payload;
    do @(posedge clk); while (!in_ready);
    expected_profiles.push_back(profile_frame(f));
    frames_sent++;
    if ((f.id == watch_id) && (f.len == watch_len))
      hits_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Only called with no frame outstanding; drops cfg_valid again after the beat
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cftr_pkg::REG_MATCH_ID)
      watch_id = data[ID_BITS-1:0];
    else if (idx == cftr_pkg::REG_MATCH_LENGTH)
      watch_len = data[LEN_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_profiles.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Registers at their reset values: identifier 0, length 0
  task automatic test_reset_defaults();
    send_frame(make_frame('0, 4'd0, 1'b0, 1'b0, 32'd100, 64'h0));
    send_frame(make_frame('0, 4'd1, 1'b1, 1'b1, 32'd150, 64'h1));
    send_frame(make_frame(29'd1, 4'd0, 1'b1, 1'b0, 32'd160, 64'h2));
    // earlier stamp than last match, gap wraps
    send_frame(make_frame('0, 4'd0, 1'b0, 1'b0, 32'd40, 64'h0101_0101_0101_0101));
    wait_for_drain();
  endtask

  // Both registers at extremes, spare indexes ignored, upper data bits masked
  task automatic test_register_writes();
    write_register(cftr_pkg::REG_MATCH_ID, '1);
    write_register(cftr_pkg::REG_MATCH_LENGTH, 29'h1FFF_FFF8);
    write_register(REG_SPARE_A, 29'h0000_0003);
    write_register(REG_SPARE_B, 29'h1555_5555);
    send_frame(make_frame('1, 4'd8, 1'b1, 1'b0, 32'hFFFF_FFFF, '1));
    send_frame(make_frame('1, 4'd8, 1'b0, 1'b1, 32'h0000_0010, 64'h0));
    send_frame(make_frame('1, 4'd7, 1'b0, 1'b0, 32'h0000_0020, 64'h5));
    send_frame(make_frame(29'h0FFF_FFFF, 4'd8, 1'b0, 1'b0, 32'h0000_0030, 64'h6));
    send_frame(make_frame('0, 4'd0, 1'b1, 1'b1, 32'h0000_0040, 64'h7));
    // zero gap, already-seen payload
    send_frame(make_frame('1, 4'd8, 1'b0, 1'b0, 32'h0000_0010, 64'h0));
    send_frame(make_frame('1, 4'd8, 1'b0, 1'b0, 32'h8000_0000, 64'hA5A5_A5A5_A5A5_A5A5));
    send_frame(make_frame('1, 4'd8, 1'b1, 1'b1, 32'h8000_0001, 64'h5A5A_5A5A_5A5A_5A5A));
    send_frame(make_frame('1, 4'd8, 1'b0, 1'b0, 32'h0123_4567, 64'h0123_4567_89AB_CDEF));
    wait_for_drain();
  endtask

  function automatic can_frame_t random_frame();
    can_frame_t f;
    frame_kind_t kind;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)       kind = KIND_MATCH;
    else if (pick == 6) kind = KIND_ID_FLIP;
    else if (pick == 7) kind = KIND_LEN_OTHER;
    else if (pick == 8) kind = KIND_ANY;
    else                kind = KIND_ANY_LEN;
    f.id = watch_id;
    f.len = watch_len;
    case (kind)
      KIND_ID_FLIP:   f.id = watch_id ^ (ID_BITS'(1) << $urandom_range(0, ID_BITS - 1));
      KIND_LEN_OTHER: f.len = LEN_BITS'((watch_len + $urandom_range(1, 8)) % 9);
      KIND_ANY: begin
        f.id = ID_BITS'($urandom);
        f.len = LEN_BITS'($urandom_range(0, 8));
      end
      KIND_ANY_LEN:   f.len = LEN_BITS'($urandom_range(0, 8));
      default: ;
    endcase
    f.ext = ($urandom_range(0, 15) == 0);
    f.rtr = ($urandom_range(0, 15) == 0);
    // mostly a steady clock, now and then a jump or a run up to the wrap
    pick = $urandom_range(0, 19);
    if (pick == 0)      stamp_now = $urandom;
    else if (pick == 1) stamp_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
    else                stamp_now = stamp_now + $urandom_range(0, 4000);
    f.stamp = stamp_now;
    // repeats of the last payload and small alphabets give repeats, wide ones give new values
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      f.payload = last_payload;
    end else if (pick == 1) begin
      for (int i = 0; i < BYTE_POSITIONS_DEF; i++)
        f.payload[i*BYTE_BITS +: BYTE_BITS] = BYTE_BITS'($urandom_range(0, 3));
    end else begin
      f.payload = {$urandom, $urandom};
    end
    last_payload = f.payload;
    return f;
  endfunction

  // Random traffic under a fresh register setting per phase
  task automatic test_random_traffic(input int first_phase, input int last_phase);
    logic [CFG_DATA_BITS-1:0] data;
    logic [LEN_BITS-1:0] len;
    int unsigned burst_left;
    bit gappy;
    for (int p = first_phase; p <= last_phase; p++) begin
      wait_for_drain();
      if (p == 0) begin
        data = '0;
        len = 4'd0;
      end else if (p == 1) begin
        data = '1;
        len = 4'd8;
      end else begin
        data = CFG_DATA_BITS'($urandom);
        len = LEN_BITS'($urandom_range(0, 8));
      end
      write_register(cftr_pkg::REG_MATCH_ID, data);
      data = CFG_DATA_BITS'($urandom);
      data[LEN_BITS-1:0] = len;
      write_register(cftr_pkg::REG_MATCH_LENGTH, data);
      case (p % 3)
        0:       rx_mode = RX_ALWAYS;
        1:       rx_mode = RX_RANDOM;
        default: rx_mode = RX_PATTERN;
      endcase
      gappy = (p != 0);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          if (gappy)
            pause_sender($urandom_range(1, 15));
          burst_left = $urandom_range(1, 24);
        end
        send_frame(random_frame());
        burst_left--;
      end
    end
    wait_for_drain();
  endtask

  // Receiver holds off while frames keep coming, so the input must stall
  task automatic test_output_backpressure();
    rx_mode = RX_ALWAYS;
    hold_len = 300;
    hold_token++;
    @(posedge clk);
    for (int n = 0; n < 12; n++)
      send_frame(make_frame(watch_id, watch_len, 1'b0, 1'b0,
                            stamp_now + 32'(n * 37), {$urandom, $urandom}));
    stamp_now = stamp_now + 32'(12 * 37);
    wait_for_drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    frame_id = '0;
    frame_length = '0;
    extended_flag = 1'b0;
    remote_flag = 1'b0;
    arrival_time = '0;
    payload = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rx_mode = RX_ALWAYS;
    hold_len = 0;
    hold_token = 0;
    frames_sent = 0;
    hits_sent = 0;
    stamp_now = '0;
    last_payload = '0;
    for (int i = 0; i < BYTE_POSITIONS_DEF; i++)
      seen_values[i] = '0;
    mean_acc = '0;
    count_acc = '0;
    last_stamp = '0;
    sticky_ext = 1'b0;
    sticky_rtr = 1'b0;
    watch_id = '0;
    watch_len = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_writes();
    test_random_traffic(0, 3);
    test_output_backpressure();
    test_random_traffic(4, PROFILE_PHASES - 1);

    wait_for_drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d frames (%0d matching) over %0d register settings, %0d results checked",
             frames_sent, hits_sent, PROFILE_PHASES + 2, results_checked);
    $display("Receiver ran free, random, patterned and with one long hold-off; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", expected_profiles.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
